/* design/mfr_pkg.sv */
`default_nettype none

package mfr_pkg;

   localparam int unsigned WORDS_PER_FRAME_DEF = 8;
   localparam logic [7:0]  MARKER_RESET        = 8'hAA;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_ID   = 3'd1,
      PH_CMD  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   typedef enum logic {
      KIND_WORD      = 1'b0,
      KIND_FRAME_END = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [5:0]         word_index;
      logic signed [31:0] word_value;
      logic [7:0]         frame_id;
      logic [7:0]         frame_cmd;
      logic               checksum_ok;
   } result_type;

   typedef struct packed {
      phase_type  phase;
      logic       push;
      kind_type   kind;
   } parse_status_type;

endpackage

`default_nettype wire

/* design/marker_frame_receiver_top.sv */
// channel  direction  handshake               payload
// req      in         req_valid / req_stall   req_rx_byte
// rsp      out        rsp_valid / rsp_stall   kind, index, value, id, cmd, checksum_ok
// csr      in         csr_wr_en               csr_wr_data (marker byte)
//
// One byte per cycle while req_stall is low; the parse state updates at the
// accepting edge, queueing any result for rsp in a two-entry output queue.
// req_stall rises only while both queue entries hold undelivered results.
// Synchronous active-high reset: hunting, marker 0xAA, queue empty.
`default_nettype none

module marker_frame_receiver_top
   import mfr_pkg::*;
#(
   parameter int unsigned WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_result_kind,
   output logic [5:0]        rsp_word_index,
   output logic signed [31:0] rsp_word_value,
   output logic [7:0]        rsp_frame_id,
   output logic [7:0]        rsp_frame_cmd,
   output logic              rsp_checksum_ok,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data
);

   logic             fifo_full;
   logic             accept;
   result_type       parse_result;
   result_type       head;
   parse_status_type status;
   logic [1:0]       fifo_count;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;

   mfr_parser #(
      .WORDS_PER_FRAME(WORDS_PER_FRAME)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .byte_valid (accept),
      .rx_byte    (req_rx_byte),
      .result     (parse_result),
      .status     (status)
   );

   mfr_result_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (status.push),
      .push_data(parse_result),
      .full     (fifo_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .head     (head),
      .count    (fifo_count)
   );

   assign rsp_result_kind = head.kind;
   assign rsp_word_index  = head.word_index;
   assign rsp_word_value  = head.word_value;
   assign rsp_frame_id    = head.frame_id;
   assign rsp_frame_cmd   = head.frame_cmd;
   assign rsp_checksum_ok = head.checksum_ok;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count != 2'd3)
      else $error("result queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !status.push)
      else $error("result pushed into full queue");

   a_frame_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (status.push && status.kind == KIND_FRAME_END) |=> status.phase == PH_HUNT)
      else $error("frame end did not return to hunting");

   a_push_shows_result: assert property (@(posedge clock) disable iff (reset)
      status.push |=> rsp_valid)
      else $error("pushed result not presented");

endmodule

`default_nettype wire

/* design/mfr_parser.sv */
`default_nettype none

module mfr_parser
   import mfr_pkg::*;
#(
   parameter int unsigned WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   input  wire logic       byte_valid,
   input  wire logic [7:0] rx_byte,
   output result_type      result,
   output parse_status_type status
);

   localparam logic [6:0] LAST_COUNT = 7'(WORDS_PER_FRAME);

   phase_type   phase_ff, phase_in;
   logic [1:0]  biw_ff, biw_in;
   logic [5:0]  count_ff, count_in;
   logic [23:0] asm_ff, asm_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  marker_ff, marker_in;
   logic        push;
   logic [6:0]  count_next;

   assign marker_in  = csr_wr_en ? csr_wr_data : marker_ff;
   assign count_next = {1'b0, count_ff} + 7'd1;

   always_comb begin
      phase_in = phase_ff;
      biw_in   = biw_ff;
      count_in = count_ff;
      asm_in   = asm_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      cmd_in   = cmd_ff;
      push     = 1'b0;
      result   = '{kind: KIND_WORD, word_index: 6'd0, word_value: 32'sd0,
                   frame_id: id_ff, frame_cmd: cmd_ff, checksum_ok: 1'b0};
      if (byte_valid) begin
         case (phase_ff)
            PH_ID: begin
               id_in    = rx_byte;
               sum_in   = sum_ff + rx_byte;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               sum_in   = sum_ff + rx_byte;
               phase_in = PH_DATA;
               biw_in   = 2'd0;
               count_in = 6'd0;
               asm_in   = 24'd0;
            end
            PH_DATA: begin
               sum_in = sum_ff + rx_byte;
               case (biw_ff)
                  2'd0: begin
                     asm_in[7:0] = rx_byte;
                     biw_in      = 2'd1;
                  end
                  2'd1: begin
                     asm_in[15:8] = rx_byte;
                     biw_in       = 2'd2;
                  end
                  2'd2: begin
                     asm_in[23:16] = rx_byte;
                     biw_in        = 2'd3;
                  end
                  default: begin
                     push              = 1'b1;
                     result.word_index = count_ff;
                     result.word_value = {rx_byte, asm_ff};
                     biw_in            = 2'd0;
                     asm_in            = 24'd0;
                     count_in          = count_next[5:0];
                     if (count_next >= LAST_COUNT) begin
                        phase_in = PH_SUM;
                     end
                  end
               endcase
            end
            PH_SUM: begin
               push               = 1'b1;
               result.kind        = KIND_FRAME_END;
               result.checksum_ok = (sum_ff == rx_byte);
               phase_in           = PH_HUNT;
               biw_in             = 2'd0;
               count_in           = 6'd0;
               asm_in             = 24'd0;
               sum_in             = 8'd0;
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx_byte == marker_ff) begin
                  sum_in   = rx_byte;
                  phase_in = PH_ID;
               end
            end
         endcase
      end
   end

   assign status = '{phase: phase_ff, push: push, kind: result.kind};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         biw_ff    <= 2'd0;
         count_ff  <= 6'd0;
         asm_ff    <= 24'd0;
         sum_ff    <= 8'd0;
         id_ff     <= 8'd0;
         cmd_ff    <= 8'd0;
         marker_ff <= MARKER_RESET;
      end else begin
         phase_ff  <= phase_in;
         biw_ff    <= biw_in;
         count_ff  <= count_in;
         asm_ff    <= asm_in;
         sum_ff    <= sum_in;
         id_ff     <= id_in;
         cmd_ff    <= cmd_in;
         marker_ff <= marker_in;
      end
   end

endmodule

`default_nettype wire

/* design/mfr_result_fifo.sv */
`default_nettype none

module mfr_result_fifo
   import mfr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output result_type head,
   output logic [1:0] count
);

   result_type  mem [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem[rd_ptr_ff];
   assign count     = count_ff;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire
